// ----- design/mkx_pkg.sv -----
// mkx_pkg: shared constants, types and MD5 tables for the keystream decryptor.
// No dependencies.
`timescale 1ns / 1ps
package mkx_pkg;
  localparam int BlockIndexBits = 27;
  localparam int KeyBytes = 22;
  localparam int KeyLen = (KeyBytes > 40) ? 40 : KeyBytes;
  localparam int DigitCnt = 10;

  typedef logic [7:0] byte_t;
  typedef logic [31:0] word_t;

  typedef struct packed {
    logic start;   // begin digest of block_index
  } cmd_t;

  typedef struct packed {
    logic done;    // digest ready (one cycle pulse)
  } sts_t;

  function automatic byte_t key_byte(input logic [5:0] i);
    byte_t k;
    unique case (i)
      6'd0, 6'd2, 6'd6, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd18, 6'd20: k = 8'h82;
      6'd1: k = 8'hBB;
      6'd3: k = 8'hCC;
      6'd4: k = 8'h89;
      6'd5: k = 8'hD4;
      6'd7: k = 8'hD1;
      6'd9: k = 8'hE7;
      6'd11: k = 8'hC9;
      6'd13: k = 8'hAD;
      6'd15: k = 8'hBF;
      6'd17: k = 8'hC3;
      6'd19: k = 8'hAF;
      6'd21: k = 8'hF0;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  function automatic word_t md5_k(input logic [5:0] i);
    word_t t [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return t[i];
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic byte_t hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
  endfunction
endpackage

// ----- design/mkx_ctrl.sv -----
// mkx_ctrl: byte-stream controller; sequences digests and the beat handshake.
// Depends on mkx_pkg.
`timescale 1ns / 1ps
module mkx_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast,
  input  logic [127:0]       digest,
  output mkx_pkg::cmd_t      cmd,
  input  mkx_pkg::sts_t      sts,
  output logic [mkx_pkg::BlockIndexBits-1:0] index
);
  typedef enum logic [1:0] {S_HASH, S_WAIT, S_RUN} state_t;
  state_t state_r;
  logic [4:0] pos_r;
  logic [mkx_pkg::BlockIndexBits-1:0] idx_r;
  logic [127:0] dig_r;
  logic ov_r;
  logic ov_nxt;
  logic [7:0] od_r;
  logic ol_r;
  logic acc;
  logic [7:0] db;
  logic [3:0] nib;

  assign in_tready = (state_r == S_RUN) && (!ov_r || out_tready);
  assign acc = in_tvalid && in_tready;
  assign ov_nxt = acc || (ov_r && !out_tready);
  assign db = dig_r[{pos_r[4:1], 3'b000} +: 8];
  assign nib = pos_r[0] ? db[3:0] : db[7:4];
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tlast = ol_r;
  assign index = idx_r;
  assign cmd.start = (state_r == S_HASH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HASH;
      pos_r <= '0;
      idx_r <= '0;
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      unique case (state_r)
        S_HASH: state_r <= S_WAIT;
        S_WAIT: begin
          if (sts.done) begin
            dig_r <= digest;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (acc) begin
            od_r <= in_tdata ^ mkx_pkg::hex_char(nib);
            ol_r <= in_tlast;
            if (in_tlast) begin
              pos_r <= '0;
              idx_r <= '0;
              state_r <= S_HASH;
            end else begin
              pos_r <= pos_r + 5'd1;
              if (pos_r == 5'd31) begin
                idx_r <= idx_r + 1'b1;
                state_r <= S_HASH;
              end
            end
          end
        end
        default: state_r <= S_HASH;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ready_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_RUN) else $error("ready outside run");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> ov_r && $stable(od_r)) else $error("output lost");
  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_tlast && pos_r == 5'd31) |=> state_r == S_HASH) else $error("no rehash");
`endif
endmodule

// ----- design/mkx_md5.sv -----
// mkx_md5: iterative MD5 datapath, decimal digit builder and one round per cycle.
// Depends on mkx_pkg.
`timescale 1ns / 1ps
module mkx_md5 (
  input  logic          clk,
  input  logic          rst_n,
  input  mkx_pkg::cmd_t cmd,
  input  logic [mkx_pkg::BlockIndexBits-1:0] index,
  output mkx_pkg::sts_t sts,
  output logic [127:0]  digest
);
  typedef enum logic [1:0] {D_IDLE, D_DIG, D_LOAD, D_RND} state_t;
  state_t state_r;
  logic [31:0] q_r;            // remaining value to split into digits
  logic [39:0] dig_r;          // BCD digits, least significant first (bits [3:0])
  logic [3:0] nd_r;
  logic [5:0] rc_r;
  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic done_r;
  logic [31:0] qd, f, sum, rot;
  logic [3:0] rem;
  logic [3:0] g;
  logic [63:0] prod;
  logic [5:0] len;

  // q/10 by reciprocal, (q * 0xCCCCCCCD) >> 35; exact for 32-bit q
  assign prod = {32'd0, q_r} * 64'hCCCCCCCD;
  assign qd = {3'd0, prod[63:35]};
  assign rem = 4'(q_r - (qd * 32'd10));
  assign len = 6'(mkx_pkg::KeyLen) + {2'd0, nd_r};

  function automatic logic [7:0] msg_byte(input logic [5:0] p, input logic [5:0] ln,
                                          input logic [39:0] dg, input logic [3:0] n);
    logic [5:0] k;
    logic [7:0] r;
    k = p - 6'(mkx_pkg::KeyLen);
    if (p < 6'(mkx_pkg::KeyLen)) r = mkx_pkg::key_byte(p);
    else if (p < ln) r = 8'h30 + {4'd0, dg[4*(n - 4'd1 - k[3:0]) +: 4]};
    else if (p == ln) r = 8'h80;
    else if (p == 6'd56) r = {ln[4:0], 3'b000};
    else if (p == 6'd57) r = {7'd0, ln[5]};
    else r = 8'h00;
    return r;
  endfunction

  always_comb begin
    unique case (rc_r[5:4])
      2'd0: begin f = (b_r & c_r) | (~b_r & d_r); g = rc_r[3:0]; end
      2'd1: begin f = (d_r & b_r) | (~d_r & c_r); g = 4'(5 * rc_r + 1); end
      2'd2: begin f = b_r ^ c_r ^ d_r; g = 4'(3 * rc_r + 5); end
      default: begin f = c_r ^ (b_r | ~d_r); g = 4'(7 * rc_r); end
    endcase
    sum = a_r + f + mkx_pkg::md5_k(rc_r) + w_r[g];
    rot = (sum << mkx_pkg::md5_s(rc_r)) | (sum >> (6'd32 - {1'b0, mkx_pkg::md5_s(rc_r)}));
  end

  assign sts.done = done_r;
  assign digest = {d_r + 32'h10325476, c_r + 32'h98badcfe,
                   b_r + 32'hefcdab89, a_r + 32'h67452301};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r <= 1'b0;
      rc_r <= '0;
    end else begin
      done_r <= (state_r == D_RND) && (rc_r == 6'd63);
      unique case (state_r)
        D_IDLE: begin
          if (cmd.start) begin
            q_r <= 32'(index);
            nd_r <= '0;
            state_r <= D_DIG;
          end
        end
        D_DIG: begin
          dig_r[4*nd_r +: 4] <= rem;
          nd_r <= nd_r + 4'd1;
          q_r <= qd;
          if (qd == 32'd0 || nd_r == 4'd9) state_r <= D_LOAD;
        end
        D_LOAD: begin
          for (int i = 0; i < 16; i++) begin
            w_r[i] <= {msg_byte(6'(4*i+3), len, dig_r, nd_r),
                       msg_byte(6'(4*i+2), len, dig_r, nd_r),
                       msg_byte(6'(4*i+1), len, dig_r, nd_r),
                       msg_byte(6'(4*i), len, dig_r, nd_r)};
          end
          a_r <= 32'h67452301; b_r <= 32'hefcdab89;
          c_r <= 32'h98badcfe; d_r <= 32'h10325476;
          rc_r <= '0;
          state_r <= D_RND;
        end
        D_RND: begin
          a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rot;
          rc_r <= rc_r + 6'd1;
          if (rc_r == 6'd63) begin
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == D_IDLE) else $error("done early");
  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == D_DIG |-> nd_r < 4'd10) else $error("digit overflow");
`endif
endmodule

// ----- design/md5_counter_keystream_xor.sv -----
// md5_counter_keystream_xor: top level, joins controller and MD5 datapath.
// Depends on mkx_pkg, mkx_ctrl, mkx_md5.
//
// channel | dir | tdata            | tlast
// in      | in  | [7:0] cipher_byte| last_byte
// out     | out | [7:0] plain_byte | last_out
//
// Each 32-byte block, and the block after a last beat, first runs a digest:
// a start step, one digit step per decimal digit of the index (one to nine),
// a load step, 64 rounds and a handoff of the digest to the controller.
// Bytes of the block then go one per cycle while the output is not stalled;
// each result shows in the cycle after its beat. Reset (rst_n low, synchronous)
// zeroes position and block index and starts digest 0. A stalled output
// register holds; input waits until it drains.
`timescale 1ns / 1ps
module md5_counter_keystream_xor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] cipher_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] plain_byte
  output logic       out_tlast
);
  mkx_pkg::cmd_t cmd;
  mkx_pkg::sts_t sts;
  logic [127:0] digest;
  logic [mkx_pkg::BlockIndexBits-1:0] index;

  mkx_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .digest, .cmd, .sts, .index
  );

  mkx_md5 u_md5 (.clk, .rst_n, .cmd, .index, .sts, .digest);
endmodule

// ----- tb/md5_counter_keystream_xor_test.sv -----
// Testbench for md5_counter_keystream_xor: checks every output beat against an in-bench
// MD5 counter keystream predictor. Depends on mkx_pkg and the design top level only.
`timescale 1ns / 1ps
module md5_counter_keystream_xor_test;

  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // [7:0] cipher_byte
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;   // [7:0] plain_byte
  logic       out_tlast;

  md5_counter_keystream_xor dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // Predictor state: keystream position and block counter.
  logic [mkx_pkg::BlockIndexBits-1:0] ks_block;
  logic [4:0]                ks_pos;
  logic [127:0]              ks_digest;   // digest bytes, byte 0 in bits [7:0]

  beat_t pending_beats[$];
  beat_t plain_expected[$];
  int    errors;
  int    accepted_in;
  int    accepted_out;
  int    lasts_seen;
  int    idle_cycles;
  int    max_block;
  bit    hold_input;
  int    in_gap;
  int    out_gap;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] rol32(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  // MD5 of key || decimal(idx), single 64-byte block.
  function automatic logic [127:0] keystream_digest(logic [mkx_pkg::BlockIndexBits-1:0] idx);
    logic [7:0]   msg[64];
    logic [7:0]   dig[10];
    logic [31:0]  w[16];
    logic [31:0]  ka[64];
    int           sh[16];
    logic [31:0]  a, b, c, d, f, t, rem;
    logic [63:0]  nbits;
    logic [127:0] res;
    int           nd, len, g;
    ka = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    sh = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    for (int i = 0; i < 64; i++) msg[i] = 8'h00;
    len = 0;
    // key table: fixed 22 bytes, zeros beyond
    msg[0] = 8'h82;  msg[1] = 8'hBB;  msg[2] = 8'h82;  msg[3] = 8'hCC;
    msg[4] = 8'h89;  msg[5] = 8'hD4;  msg[6] = 8'h82;  msg[7] = 8'hD1;
    msg[8] = 8'h82;  msg[9] = 8'hE7;  msg[10] = 8'h82; msg[11] = 8'hC9;
    msg[12] = 8'h82; msg[13] = 8'hAD; msg[14] = 8'h82; msg[15] = 8'hBF;
    msg[16] = 8'h82; msg[17] = 8'hC3; msg[18] = 8'h82; msg[19] = 8'hAF;
    msg[20] = 8'h82; msg[21] = 8'hF0;
    for (int i = mkx_pkg::KeyLen; i < 40; i++) msg[i] = 8'h00;
    len = mkx_pkg::KeyLen;
    nd = 0;
    rem = 32'(idx);
    do begin
      dig[nd] = 8'h30 + 8'(rem % 10);
      rem = rem / 10;
      nd++;
    end while (rem != 0 && nd < 10);
    while (nd > 0) begin
      nd--;
      msg[len] = dig[nd];
      len++;
    end
    msg[len] = 8'h80;
    nbits = 64'(len) * 8;
    for (int i = 0; i < 8; i++) msg[56 + i] = nbits[8*i +: 8];
    for (int i = 0; i < 16; i++) w[i] = {msg[4*i+3], msg[4*i+2], msg[4*i+1], msg[4*i]};
    a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * i) % 16;
      end
      t = d;
      d = c;
      c = b;
      b = b + rol32(a + f + ka[i] + w[g], sh[((i / 16) * 4) + (i % 4)]);
      a = t;
    end
    res = {d + 32'h10325476, c + 32'h98badcfe, b + 32'hefcdab89, a + 32'h67452301};
    return res;
  endfunction

  function automatic logic [7:0] nibble_char(logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
  endfunction

  // Advance the keystream by one accepted input beat.
  task automatic decrypt_beat(input beat_t b);
    beat_t      r;
    logic [7:0] db;
    logic [7:0] ks;
    if (ks_pos == 5'd0) ks_digest = keystream_digest(ks_block);
    db = ks_digest[8*ks_pos[4:1] +: 8];
    ks = ks_pos[0] ? nibble_char(db[3:0]) : nibble_char(db[7:4]);
    r.data = b.data ^ ks;
    r.last = b.last;
    plain_expected.push_back(r);
    if (b.last) begin
      ks_pos = 5'd0;
      ks_block = '0;
    end else begin
      ks_pos = ks_pos + 5'd1;
      if (ks_pos == 5'd0) begin
        ks_block = ks_block + 1'b1;
        if (int'(ks_block) > max_block) max_block = int'(ks_block);
      end
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic beat_t mk_beat(logic [7:0] d, logic l);
    beat_t b;
    b.data = d;
    b.last = l;
    return b;
  endfunction

  // Driver: feeds pending beats; holds tvalid across back-to-back beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tlast  <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        decrypt_beat(mk_beat(in_tdata, in_tlast));
        accepted_in++;
        if (in_tlast) lasts_seen++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0 && !hold_input) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_beats[0].data;
          in_tlast  <= pending_beats[0].last;
          void'(pending_beats.pop_front());
          in_gap <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure and compare against the oldest expected beat.
  always @(posedge clk) begin
    beat_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        accepted_out++;
        if (plain_expected.size() == 0) begin
          $error("unexpected output beat data=%h last=%b", out_tdata, out_tlast);
          errors++;
        end else begin
          e = plain_expected.pop_front();
          if (out_tdata !== e.data) begin
            $error("plain_byte: expected %h, got %h", e.data, out_tdata);
            errors++;
          end
          if (out_tlast !== e.last) begin
            $error("last_out: expected %b, got %b", e.last, out_tlast);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap    <= pick_gap();
      end
    end
  end

  // Watchdog: counts cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no progress, %0d beats still expected", plain_expected.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Queue a frame of n random bytes, last on the final one if asked.
  task automatic add_frame(input int n, input bit with_last);
    for (int i = 0; i < n; i++)
      pending_beats.push_back(mk_beat(8'($urandom), with_last && (i == n - 1)));
  endtask

  initial begin
    int total;
    errors = 0; accepted_in = 0; accepted_out = 0; lasts_seen = 0;
    idle_cycles = 0; max_block = 0; hold_input = 1'b0;
    ks_block = '0; ks_pos = 5'd0; ks_digest = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = 8'h00; in_tlast = 1'b0; out_tready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: data extremes, last on the very first byte, last mid-block.
    pending_beats.push_back(mk_beat(8'h00, 1'b1));
    pending_beats.push_back(mk_beat(8'hFF, 1'b0));
    pending_beats.push_back(mk_beat(8'h00, 1'b0));
    pending_beats.push_back(mk_beat(8'hAA, 1'b0));
    pending_beats.push_back(mk_beat(8'h55, 1'b1));   // last in the middle of a block
    for (int i = 0; i < 8; i++)
      pending_beats.push_back(mk_beat(8'(1 << i), 1'b0));
    pending_beats.push_back(mk_beat(8'hFF, 1'b1));
    // Pause until everything drains.
    wait (pending_beats.size() == 0);
    hold_input = 1'b1;
    wait (plain_expected.size() == 0 && !in_tvalid);
    hold_input = 1'b0;

    // Random: mostly long frames to cross many blocks and multi-digit indexes,
    // plus short frames and frames ending on block edges.
    total = 0;
    while (total < 616) begin
      int n;
      int k;
      k = $urandom_range(0, 9);
      if (k < 3) n = $urandom_range(1, 8);
      else if (k < 5) n = 32 * $urandom_range(1, 3) + $urandom_range(0, 1);
      else n = $urandom_range(40, 360);
      if (n > 616 - total) n = 616 - total;
      add_frame(n, 1'b1);
      total += n;
    end
    add_frame(20, 1'b0);   // trailing bytes with no last
    wait (pending_beats.size() == 0);
    wait (plain_expected.size() == 0 && !in_tvalid);
    repeat (100) @(posedge clk);

    $display("ran %0d input beats, %0d frames, %0d output beats; highest block index %0d",
             accepted_in, lasts_seen, accepted_out, max_block);
    if (errors == 0 && plain_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
